// ===== src/tbpm_pkg.sv =====
// ============================================================================
// tbpm_pkg
// Shared types and constants for the two-button press mode controller.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tbpm_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned THRESH_W = 16;
    localparam int unsigned MODE_W   = 2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1000;

    // Slave tdata: now_ms, mode level, clear level, padded to whole bytes.
    localparam int unsigned IN_BITS   = TIME_W + 2;
    localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    // Master tdata: mode, counter clear, mode short, mode long, clear short.
    localparam int unsigned OUT_BITS   = MODE_W + 4;
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 2'd0,
        MODE_HAND   = 2'd1,
        MODE_TARGET = 2'd2
    } mode_t;

    typedef struct packed {
        logic tap;
        logic hold;
    } btn_event_t;

endpackage : tbpm_pkg

`default_nettype wire

// ===== src/two_button_press_mode_controller_core.sv =====
// ============================================================================
// two_button_press_mode_controller_core
// Two-button short/long press detector driving a mode and a counter clear.
// ============================================================================
// Each input beat carries one button sample with a millisecond timestamp and
// yields exactly one output beat. A sample is registered on entry, classified
// by short logic and written to the output register once it is free, so a
// beat can be taken every clock while the master keeps up; the output register
// decouples the two sides, and a stalled master only holds the input once both
// registers are full. The threshold register resets to 1000 ms; the user writes
// it via cfg_wr_en/cfg_wr_data while no beat is in flight; this is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module two_button_press_mode_controller_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tbpm_pkg::THRESH_W-1:0]      cfg_wr_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [31:0] now_ms, [32] mode_button_level, [33] clear_button_level
    input  wire logic [tbpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [1:0] encoder_mode, [2] counter_clear, [3] mode_short_event,
    // [4] mode_long_event, [5] clear_short_event
    output logic [tbpm_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
    import tbpm_pkg::*;

    logic [THRESH_W-1:0] threshold_reg;

    logic                in_valid_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                mode_level_reg;
    logic                clear_level_reg;

    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg, out_data_next;

    logic                out_free;
    logic                step;
    btn_event_t          mode_ev;
    btn_event_t          clear_ev;
    mode_t               mode_after;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            now_reg         <= s_axis_tdata[TIME_W-1:0];
            mode_level_reg  <= s_axis_tdata[TIME_W];
            clear_level_reg <= s_axis_tdata[TIME_W+1];
        end
    end

    tbpm_button u_mode_button (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .level     (mode_level_reg),
        .now_ms    (now_reg),
        .threshold (threshold_reg),
        .events    (mode_ev)
    );

    tbpm_button u_clear_button (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .level     (clear_level_reg),
        .now_ms    (now_reg),
        .threshold (threshold_reg),
        .events    (clear_ev)
    );

    tbpm_mode_ctrl u_mode_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .events     (mode_ev),
        .mode_after (mode_after)
    );

    assign out_data_next = {clear_ev.tap, mode_ev.hold,
                            mode_ev.tap, clear_ev.hold, mode_after};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_data_reg};

`ifndef SYNTH
    // A clear button sample gives a long press or a short press, never both.
    a_clear_events_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[5]))
        else $error("clear button reported short and long press together");

    // A mode short press always lands in off or target.
    a_short_not_hand : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[1:0] != MODE_HAND))
        else $error("mode short press left mode in hand");

    // A mode long press always lands in off or hand.
    a_long_not_target : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tdata[1:0] != MODE_TARGET))
        else $error("mode long press left mode in target");

    // The unused mode code is never reachable from reset.
    a_mode_legal : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("mode took the unused code");
`endif

endmodule : two_button_press_mode_controller_core

`default_nettype wire

// ===== src/tbpm_button.sv =====
// ============================================================================
// tbpm_button
// Short/long press classifier for one active-low button.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tbpm_button (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic                           level,
    input  wire logic [tbpm_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [tbpm_pkg::THRESH_W-1:0]  threshold,
    output tbpm_pkg::btn_event_t                events
);
    import tbpm_pkg::*;

    logic              prev_level_reg, prev_level_next;
    logic              held_reg, held_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;

    logic              press;
    logic              release_held;
    logic              held_now;
    logic [TIME_W-1:0] elapsed;
    logic              reached;

    always_comb
    begin
        press            = !level && prev_level_reg;
        held_now         = press ? 1'b1 : held_reg;
        press_start_next = press ? now_ms : press_start_reg;
        // Wraps modulo 2^32, so a timer rollover does not disturb the hold time.
        elapsed          = now_ms - press_start_next;
        reached          = elapsed >= {{(TIME_W-THRESH_W){1'b0}}, threshold};
        release_held     = level && !prev_level_reg && held_reg;

        events.tap  = release_held && !reached;
        events.hold = !level && held_now && reached;

        held_next       = (release_held || events.hold) ? 1'b0 : held_now;
        prev_level_next = level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg  <= 1'b1;
            held_reg        <= 1'b0;
            press_start_reg <= '0;
        end
        else if (step)
        begin
            prev_level_reg  <= prev_level_next;
            held_reg        <= held_next;
            press_start_reg <= press_start_next;
        end
    end

endmodule : tbpm_button

`default_nettype wire

// ===== src/tbpm_mode_ctrl.sv =====
// ============================================================================
// tbpm_mode_ctrl
// Three-state mode (off, hand, target) stepped by mode button events.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tbpm_mode_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire tbpm_pkg::btn_event_t  events,
    output tbpm_pkg::mode_t            mode_after
);
    import tbpm_pkg::*;

    mode_t state_reg, state_next;

    // Short and long presses cannot arrive in the same sample.
    always_comb
    begin
        state_next = state_reg;
        if (events.hold)
        begin
            unique case (state_reg)
                MODE_OFF:    state_next = MODE_HAND;
                MODE_HAND:   state_next = MODE_OFF;
                MODE_TARGET: state_next = MODE_HAND;
                default:     state_next = state_reg;
            endcase
        end
        else if (events.tap)
        begin
            unique case (state_reg)
                MODE_OFF:    state_next = MODE_TARGET;
                MODE_HAND:   state_next = MODE_OFF;
                MODE_TARGET: state_next = MODE_OFF;
                default:     state_next = state_reg;
            endcase
        end
    end

    always_comb
    begin
        mode_after = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MODE_OFF;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule : tbpm_mode_ctrl

`default_nettype wire

// ===== bench/two_button_press_mode_controller_core_test.sv =====
// ============================================================================
// two_button_press_mode_controller_core_test
// Self-checking bench for the two-button short/long press mode controller.
// ============================================================================
// Button samples are streamed into the core while a behavioral model of the
// press classifier and the mode state machine predicts every output beat.
// A directed part covers the reset threshold, each mode transition, releases
// at the threshold, timestamp wrap and the smallest and largest thresholds.
// Random press sequences then run under several thresholds, with bursty input
// traffic, stalling output traffic and one long output hold-off.
`timescale 1ns / 1ps

module two_button_press_mode_controller_core_test;

    import tbpm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam int BTN_MODE  = 0;
    localparam int BTN_CLEAR = 1;

    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;
    localparam int RX_SPARSE  = 3;

    typedef struct packed {
        logic              prev_level;
        logic              held;
        logic [TIME_W-1:0] press_start;
    } button_track_t;

    typedef struct packed {
        mode_t mode;
        logic  counter_clear;
        logic  mode_short;
        logic  mode_long;
        logic  clear_short;
    } panel_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [THRESH_W-1:0]   cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Model state.
    button_track_t       btn_track [2];
    mode_t               panel_mode;
    logic [THRESH_W-1:0] hold_thresh_ms;

    panel_result_t expected_panel_q [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned beat_count     = 0;

    // Traffic shaping.
    int unsigned gap_max      = 0;
    int unsigned burst_left   = 0;
    int          rx_style     = RX_ALWAYS;
    int unsigned hold_off_req = 0;
    int unsigned hold_left    = 0;
    logic [15:0] rx_pattern   = 16'b1110_1101_0011_1011;

    two_button_press_mode_controller_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Output side: a long hold-off when requested, otherwise the current style.
    always @(posedge clk)
    begin
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        if (hold_off_req != 0)
        begin
            hold_left    = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            case (rx_style)
                RX_ALWAYS:  m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_axis_tready <= rx_pattern[0];
                default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
            $display("MISMATCH beat %0d %s: got %0h, expected %0h",
                     beat_count, what, got, want);
        mismatch_count++;
    endtask

    // Press classification of one button; updates its tracking state.
    function automatic btn_event_t classify_press(input int idx, input logic level,
                                                  input logic [TIME_W-1:0] now);
        btn_event_t        ev;
        button_track_t     b;
        logic [TIME_W-1:0] held_ms;
        ev = '0;
        b  = btn_track[idx];
        if (!level && b.prev_level)
        begin
            b.press_start = now;
            b.held        = 1'b1;
        end
        // Held time wraps modulo 2^32 together with the timestamp.
        held_ms = now - b.press_start;
        if (level && !b.prev_level && b.held)
        begin
            if (held_ms < hold_thresh_ms)
                ev.tap = 1'b1;
            b.held = 1'b0;
        end
        if (!level && b.held && held_ms >= hold_thresh_ms)
        begin
            ev.hold = 1'b1;
            b.held  = 1'b0;
        end
        b.prev_level   = level;
        btn_track[idx] = b;
        return ev;
    endfunction

    function automatic panel_result_t predict_panel(input logic [TIME_W-1:0] now,
                                                    input logic mode_lvl,
                                                    input logic clear_lvl);
        panel_result_t res;
        btn_event_t    mode_ev;
        btn_event_t    clear_ev;
        mode_ev = classify_press(BTN_MODE, mode_lvl, now);
        if (mode_ev.hold)
        begin
            case (panel_mode)
                MODE_OFF:    panel_mode = MODE_HAND;
                MODE_HAND:   panel_mode = MODE_OFF;
                MODE_TARGET: panel_mode = MODE_HAND;
                default:     ;
            endcase
        end
        if (mode_ev.tap)
        begin
            case (panel_mode)
                MODE_OFF:    panel_mode = MODE_TARGET;
                MODE_HAND:   panel_mode = MODE_OFF;
                MODE_TARGET: panel_mode = MODE_OFF;
                default:     ;
            endcase
        end
        clear_ev          = classify_press(BTN_CLEAR, clear_lvl, now);
        res.mode          = panel_mode;
        res.counter_clear = clear_ev.hold;
        res.mode_short    = mode_ev.tap;
        res.mode_long     = mode_ev.hold;
        res.clear_short   = clear_ev.tap;
        return res;
    endfunction

    // Result check: [1:0] mode, [2] clear, [3] mode short, [4] mode long,
    // [5] clear short.
    always @(posedge clk)
    begin : check_panel
        panel_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_panel_q.size() == 0)
                report_mismatch("unexpected beat", 32'(m_axis_tdata), 32'd0);
            else
            begin
                want = expected_panel_q.pop_front();
                if (m_axis_tdata[1:0] !== want.mode)
                    report_mismatch("encoder_mode", 32'(m_axis_tdata[1:0]), 32'(want.mode));
                if (m_axis_tdata[2] !== want.counter_clear)
                    report_mismatch("counter_clear", 32'(m_axis_tdata[2]),
                                    32'(want.counter_clear));
                if (m_axis_tdata[3] !== want.mode_short)
                    report_mismatch("mode_short_event", 32'(m_axis_tdata[3]),
                                    32'(want.mode_short));
                if (m_axis_tdata[4] !== want.mode_long)
                    report_mismatch("mode_long_event", 32'(m_axis_tdata[4]),
                                    32'(want.mode_long));
                if (m_axis_tdata[5] !== want.clear_short)
                    report_mismatch("clear_short_event", 32'(m_axis_tdata[5]),
                                    32'(want.clear_short));
            end
            beat_count++;
        end
    end

    // Offers one sample and waits for it to be taken. The valid stays high
    // inside a burst so the next call continues without a bubble.
    task automatic send_sample(input logic [TIME_W-1:0] now, input logic mode_lvl,
                               input logic clear_lvl);
        s_axis_tdata  <= IN_DATA_W'({clear_lvl, mode_lvl, now});
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_panel_q.push_back(predict_panel(now, mode_lvl, clear_lvl));
        if (burst_left > 0)
            burst_left--;
        else if (gap_max > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_panel_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_threshold(input logic [THRESH_W-1:0] value);
        wait_idle();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        hold_thresh_ms = value;
    endtask

    // Reset threshold of 1000 ms; walks the mode through all six transitions.
    task automatic test_default_threshold();
        gap_max  = 2;
        rx_style = RX_RANDOM;
        send_sample(32'hFFFF_FF00, 1'b0, 1'b1);
        send_sample(32'h0000_0100, 1'b1, 1'b1);   // short across the wrap
        send_sample(32'd1000, 1'b0, 1'b0);
        send_sample(32'd1999, 1'b0, 1'b0);
        send_sample(32'd2000, 1'b0, 1'b0);        // both long
        send_sample(32'd2500, 1'b1, 1'b1);        // release after long
        send_sample(32'd3000, 1'b0, 1'b0);
        send_sample(32'd4000, 1'b1, 1'b1);        // release exactly at threshold
        send_sample(32'd5000, 1'b0, 1'b1);
        send_sample(32'd5999, 1'b1, 1'b0);
        send_sample(32'd6000, 1'b0, 1'b1);
        send_sample(32'd7000, 1'b0, 1'b1);
        send_sample(32'd7100, 1'b1, 1'b1);
        send_sample(32'd7200, 1'b0, 1'b1);
        send_sample(32'd8200, 1'b0, 1'b1);
        send_sample(32'd8300, 1'b1, 1'b1);
        send_sample(32'd8400, 1'b0, 1'b1);
        send_sample(32'd8500, 1'b1, 1'b1);
        send_sample(32'd8600, 1'b0, 1'b1);
        send_sample(32'd8700, 1'b1, 1'b1);
    endtask

    task automatic test_threshold_corners();
        set_threshold(16'hFFFF);
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_sample(32'h0000_FFFE, 1'b1, 1'b1);
        set_threshold(16'd1);
        send_sample(32'd10, 1'b0, 1'b0);
        send_sample(32'd10, 1'b1, 1'b1);          // zero hold time is short
        send_sample(32'd20, 1'b0, 1'b0);
        send_sample(32'd21, 1'b0, 1'b0);
        // A zero threshold reports the press as long on the falling sample.
        set_threshold(16'd0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h5555_AAAA, 1'b1, 1'b1);
    endtask

    // Press sequences with time steps scaled to the threshold, plus jumps
    // and fully random samples as noise.
    task automatic test_random_presses(input int unsigned count,
                                       input logic [THRESH_W-1:0] thr,
                                       input int unsigned gap_max_i,
                                       input int rx_style_i);
        logic [TIME_W-1:0] now;
        logic              mode_lvl;
        logic              clear_lvl;
        int unsigned       pick;
        int unsigned       span;
        set_threshold(thr);
        gap_max   = gap_max_i;
        rx_style  = rx_style_i;
        now       = $urandom;
        mode_lvl  = btn_track[BTN_MODE].prev_level;
        clear_lvl = btn_track[BTN_CLEAR].prev_level;
        span      = (thr == 0) ? 8 : 2 * int'(thr);
        repeat (count)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                now = $urandom;
            else if (pick == 1)
                now = now + thr;
            else if (pick == 2)
            begin
                now       = $urandom;
                mode_lvl  = 1'($urandom);
                clear_lvl = 1'($urandom);
            end
            else
                now = now + $urandom_range(0, span / 2);
            if ($urandom_range(0, 9) < 3)
                mode_lvl = !mode_lvl;
            if ($urandom_range(0, 9) < 3)
                clear_lvl = !clear_lvl;
            send_sample(now, mode_lvl, clear_lvl);
        end
    endtask

    // The output holds off for a long stretch while samples keep coming, so
    // both internal registers fill and the input must stall.
    task automatic test_output_backpressure();
        logic [TIME_W-1:0] now;
        logic [7:0]        k;
        set_threshold(16'd20);
        gap_max      = 0;
        rx_style     = RX_ALWAYS;
        hold_off_req = 300;
        now          = 32'd5000;
        for (k = 8'd0; k < 8'd40; k++)
        begin
            now = now + $urandom_range(0, 15);
            send_sample(now, k[2], k[3]);
        end
    endtask

    initial
    begin
        btn_track[BTN_MODE]  = '{prev_level: 1'b1, held: 1'b0, press_start: '0};
        btn_track[BTN_CLEAR] = '{prev_level: 1'b1, held: 1'b0, press_start: '0};
        panel_mode     = MODE_OFF;
        hold_thresh_ms = THRESH_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_threshold();
        test_threshold_corners();
        test_random_presses(140, 16'($urandom_range(2, 40)), 4, RX_RANDOM);
        test_random_presses(120, 16'd1, 0, RX_ALWAYS);
        test_random_presses(120, 16'hFFFF, 8, RX_PATTERN);
        test_random_presses(140, 16'($urandom_range(100, 5000)), 3, RX_SPARSE);
        test_random_presses(140, 16'($urandom_range(1, 65535)), 2, RX_RANDOM);
        test_random_presses(60, 16'd0, 1, RX_PATTERN);
        test_random_presses(90, THRESH_RESET, 5, RX_RANDOM);
        test_output_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
